/* rtl/btd_pkg.sv */
// ----------------------------------------------------------------------------
// btd_pkg
// Shared types, codes and decode functions for the BOM-aware text decoder
// and line splitter.
// ----------------------------------------------------------------------------
package btd_pkg;

  // result slots per accepted word: three replayed bytes, error, end of file
  localparam int NumSlots          = 5;
  localparam int SlotErr           = 3;
  localparam int SlotEof           = 4;
  localparam int QueueDepthDefault = 2;

  // input op codes
  localparam logic OP_DATA = 1'b0;
  localparam logic OP_EOF  = 1'b1;

  // encodings
  localparam logic [1:0] ENC_ASCII   = 2'd0;
  localparam logic [1:0] ENC_UTF8    = 2'd1;
  localparam logic [1:0] ENC_UTF16LE = 2'd2;
  localparam logic [1:0] ENC_UTF16BE = 2'd3;
  localparam logic [1:0] ENC_RESET   = ENC_UTF8;

  // result kinds
  localparam logic [1:0] KIND_CHAR  = 2'd0;
  localparam logic [1:0] KIND_BREAK = 2'd1;
  localparam logic [1:0] KIND_EOF   = 2'd2;
  localparam logic [1:0] KIND_TRUNC = 2'd3;

  // pending line terminator
  localparam logic [1:0] PEND_NONE = 2'd0;
  localparam logic [1:0] PEND_CR   = 2'd1;
  localparam logic [1:0] PEND_LF   = 2'd2;

  // byte-order mark bytes
  localparam logic [7:0] BOM_EF = 8'hEF;
  localparam logic [7:0] BOM_BB = 8'hBB;
  localparam logic [7:0] BOM_BF = 8'hBF;
  localparam logic [7:0] BOM_FF = 8'hFF;
  localparam logic [7:0] BOM_FE = 8'hFE;

  localparam logic [15:0] CHAR_CR = 16'h000D;
  localparam logic [15:0] CHAR_LF = 16'h000A;

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] code_unit;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [1:0]  active_encoding;
    logic [15:0] partial_value;
    logic [1:0]  bytes_left;
    logic [1:0]  pending_terminator;
  } dec_state_t;

  typedef struct packed {
    logic        valid;
    logic [1:0]  kind;
    logic [15:0] code_unit;
  } slot_t;

  typedef struct packed {
    dec_state_t st;
    slot_t      res;
  } dec_step_t;

  typedef struct packed {
    slot_t [NumSlots-1:0] slots;
  } bundle_t;

  // Line-terminator folding: CRLF and LFCR give a single break
  function automatic dec_step_t put_unit(dec_state_t st, logic [15:0] u);
    dec_step_t r;
    logic      swallow;
    r       = '0;
    r.st    = st;
    swallow = 1'b0;
    if (st.pending_terminator != PEND_NONE) begin
      r.st.pending_terminator = PEND_NONE;
      swallow = (st.pending_terminator == PEND_CR) ? (u == CHAR_LF) : (u == CHAR_CR);
    end
    if (!swallow) begin
      if (u == CHAR_CR) begin
        r.res.valid             = 1'b1;
        r.res.kind              = KIND_BREAK;
        r.st.pending_terminator = PEND_CR;
      end else if (u == CHAR_LF) begin
        r.res.valid             = 1'b1;
        r.res.kind              = KIND_BREAK;
        r.st.pending_terminator = PEND_LF;
      end else begin
        r.res.valid     = 1'b1;
        r.res.kind      = KIND_CHAR;
        r.res.code_unit = u;
      end
    end
    return r;
  endfunction

  // One byte through the active decoder
  function automatic dec_step_t decode_byte(dec_state_t st, logic [7:0] b);
    dec_step_t   r;
    dec_state_t  s;
    logic [15:0] pv;
    r  = '0;
    r.st = st;
    s  = st;
    pv = '0;
    case (st.active_encoding)
      ENC_ASCII: begin
        r = put_unit(st, {8'h00, b});
      end
      ENC_UTF8: begin
        if (st.bytes_left != 2'd0) begin
          pv              = {st.partial_value[9:0], b[5:0]};
          s.partial_value = pv;
          s.bytes_left    = st.bytes_left - 2'd1;
          r.st            = s;
          if (st.bytes_left == 2'd1) begin
            r = put_unit(s, pv);
          end
        end else if (!b[7]) begin
          r = put_unit(st, {8'h00, b});
        end else if (b[7:5] == 3'b110) begin
          r.st.partial_value = {11'd0, b[4:0]};
          r.st.bytes_left    = 2'd1;
        end else if (b[7:4] == 4'b1110) begin
          r.st.partial_value = {12'd0, b[3:0]};
          r.st.bytes_left    = 2'd2;
        end else begin
          // bad lead: sign-extended byte
          r = put_unit(st, {8'hFF, b});
        end
      end
      default: begin
        // UTF-16, either byte order
        if (st.bytes_left != 2'd0) begin
          s.bytes_left = 2'd0;
          if (st.active_encoding == ENC_UTF16LE) begin
            pv = {b, st.partial_value[7:0]};
          end else begin
            pv = {st.partial_value[7:0], b};
          end
          r = put_unit(s, pv);
        end else begin
          r.st.partial_value = {8'h00, b};
          r.st.bytes_left    = 2'd1;
        end
      end
    endcase
    return r;
  endfunction

endpackage

/* rtl/btd_front.sv */
// ----------------------------------------------------------------------------
// btd_front
// Accepts input words, holds leading bytes for mark detection, runs the
// decoder state and emits at most one result bundle per word.
// ----------------------------------------------------------------------------
module btd_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_data,
  input  logic              item_valid,
  output logic              item_ready,
  input  btd_pkg::item_t    item,
  output logic              push_valid,
  input  logic              push_ready,
  output btd_pkg::bundle_t  push_bundle
);

  logic [1:0]          default_encoding;
  logic [7:0]          mark_buffer [2];
  logic [1:0]          mark_count;
  logic                mark_done;
  btd_pkg::dec_state_t st;

  logic [1:0]          mark_count_next;
  logic                mark_done_next;
  btd_pkg::dec_state_t st_next;
  logic                accept;

  assign item_ready = push_ready;
  assign accept     = item_valid && push_ready;

  // Mark settle, decode and end-of-file handling for one word
  always_comb begin : front_logic
    btd_pkg::dec_step_t  stp;
    btd_pkg::dec_state_t st_w;
    logic [7:0]          b [3];
    logic [1:0]          n;
    logic [1:0]          skip;
    logic [1:0]          enc;
    logic                settle;
    logic                any;
    stp             = '0;
    st_w            = st;
    push_bundle     = '0;
    st_next         = st;
    mark_count_next = mark_count;
    mark_done_next  = mark_done;
    settle          = 1'b0;

    b[0] = mark_buffer[0];
    b[1] = mark_buffer[1];
    b[2] = item.data_byte;
    n    = (item.op == btd_pkg::OP_EOF) ? mark_count : 2'd3;

    // mark detection
    enc  = default_encoding;
    skip = 2'd0;
    if (n == 2'd3 && b[0] == btd_pkg::BOM_EF && b[1] == btd_pkg::BOM_BB &&
        b[2] == btd_pkg::BOM_BF) begin
      enc  = btd_pkg::ENC_UTF8;
      skip = 2'd3;
    end else if (n >= 2'd2 && b[0] == btd_pkg::BOM_FF && b[1] == btd_pkg::BOM_FE) begin
      enc  = btd_pkg::ENC_UTF16LE;
      skip = 2'd2;
    end else if (n >= 2'd2 && b[0] == btd_pkg::BOM_FE && b[1] == btd_pkg::BOM_FF) begin
      enc  = btd_pkg::ENC_UTF16BE;
      skip = 2'd2;
    end

    if (accept) begin
      if (item.op == btd_pkg::OP_DATA) begin
        if (!mark_done) begin
          if (mark_count == 2'd2) begin
            settle = 1'b1;
          end else begin
            mark_count_next = mark_count + 2'd1;
          end
        end else begin
          stp                  = btd_pkg::decode_byte(st, item.data_byte);
          st_next              = stp.st;
          push_bundle.slots[0] = stp.res;
        end
      end else begin
        settle = !mark_done;
      end
    end

    // replay held bytes in the settled encoding
    if (settle) begin
      st_w                 = st;
      st_w.active_encoding = enc;
      for (int i = 0; i < 3; i++) begin
        if (2'(i) >= skip && 2'(i) < n) begin
          stp                  = btd_pkg::decode_byte(st_w, b[i]);
          st_w                 = stp.st;
          push_bundle.slots[i] = stp.res;
        end
      end
      st_next         = st_w;
      mark_done_next  = 1'b1;
      mark_count_next = 2'd0;
    end

    // end of file: optional truncation error, then the end marker
    if (accept && item.op == btd_pkg::OP_EOF) begin
      if (st_next.bytes_left != 2'd0) begin
        push_bundle.slots[btd_pkg::SlotErr] = {1'b1, btd_pkg::KIND_TRUNC, 16'd0};
      end
      push_bundle.slots[btd_pkg::SlotEof] = {1'b1, btd_pkg::KIND_EOF, 16'd0};
      st_next         = '0;
      mark_count_next = 2'd0;
      mark_done_next  = 1'b0;
    end

    any = 1'b0;
    for (int i = 0; i < btd_pkg::NumSlots; i++) begin
      any = any | push_bundle.slots[i].valid;
    end
    push_valid = accept && any;
  end

  // Stream state and config register
  always_ff @(posedge clk) begin
    if (rst) begin
      default_encoding <= btd_pkg::ENC_RESET;
      mark_count       <= 2'd0;
      mark_done        <= 1'b0;
      st               <= '0;
    end else begin
      if (cfg_we) begin
        default_encoding <= cfg_data;
      end
      mark_count <= mark_count_next;
      mark_done  <= mark_done_next;
      st         <= st_next;
    end
  end

  // Held mark bytes, no reset
  always_ff @(posedge clk) begin
    if (accept && item.op == btd_pkg::OP_DATA && !mark_done && mark_count != 2'd2) begin
      mark_buffer[mark_count[0]] <= item.data_byte;
    end
  end

endmodule

/* rtl/btd_queue.sv */
// ----------------------------------------------------------------------------
// btd_queue
// Short FIFO of result bundles between the front and back halves.
// ----------------------------------------------------------------------------
module btd_queue #(
  parameter int Depth = btd_pkg::QueueDepthDefault
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  output logic              push_ready,
  input  btd_pkg::bundle_t  push_bundle,
  output logic              pop_valid,
  input  logic              pop_ready,
  output btd_pkg::bundle_t  pop_bundle
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  btd_pkg::bundle_t entries [Depth];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CntW'(Depth));
  assign pop_valid  = (count != '0);
  assign pop_bundle = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_bundle;
    end
  end

endmodule

/* rtl/btd_back.sv */
// ----------------------------------------------------------------------------
// btd_back
// Takes one bundle at a time and sends its valid slots out in order, one
// result word per cycle while result_ready is high, marking the final one.
// ----------------------------------------------------------------------------
module btd_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              pop_valid,
  output logic              pop_ready,
  input  btd_pkg::bundle_t  pop_bundle,
  output logic              result_valid,
  input  logic              result_ready,
  output btd_pkg::result_t  result
);

  localparam int N = btd_pkg::NumSlots;

  btd_pkg::bundle_t cur;
  logic [N-1:0]     mask;
  logic [N-1:0]     lowest;
  logic [N-1:0]     rest;
  logic [N-1:0]     load_mask;
  logic             advance;

  // Lowest pending slot and what stays after it
  assign lowest       = mask & (~mask + 1'b1);
  assign rest         = mask & ~lowest;
  assign result_valid = (mask != '0);
  assign advance      = !result_valid || (result_ready && rest == '0);
  assign pop_ready    = advance;

  always_comb begin
    result.kind      = '0;
    result.code_unit = '0;
    for (int i = 0; i < N; i++) begin
      if (lowest[i]) begin
        result.kind      = result.kind | cur.slots[i].kind;
        result.code_unit = result.code_unit | cur.slots[i].code_unit;
      end
      load_mask[i] = pop_bundle.slots[i].valid;
    end
    result.last = (rest == '0);
  end

  // Slot mask
  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
    end else if (result_valid && result_ready && rest != '0) begin
      mask <= rest;
    end else if (advance) begin
      mask <= pop_valid ? load_mask : '0;
    end
  end

  // Bundle payload
  always_ff @(posedge clk) begin
    if (advance && pop_valid) begin
      cur <= pop_bundle;
    end
  end

endmodule

/* rtl/bom_text_decoder_line_splitter.sv */
// ----------------------------------------------------------------------------
// bom_text_decoder_line_splitter
// Byte-stream text decoder with byte-order-mark detection and CR/LF folding.
//
//   channel   | dir | handshake                  | payload
//   ----------+-----+----------------------------+---------------------------
//   item      | in  | item_valid / item_ready    | op, data_byte
//   result    | out | result_valid / result_ready| kind, code_unit, last
//   config    | in  | cfg_we                     | cfg_data (default_encoding)
//
// One input word per cycle is accepted while the bundle queue has room.
// Results leave one per cycle while result_ready is high. A word's results pass
// through a queue entry and then the back's registered slot mask and bundle.
// The queue holds QueueDepth bundles, so each side stalls on its own.
// Synchronous reset clears stream state, queue and output; encoding -> UTF-8.
// ----------------------------------------------------------------------------
module bom_text_decoder_line_splitter #(
  parameter int QueueDepth = btd_pkg::QueueDepthDefault
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_data,
  input  logic              item_valid,
  output logic              item_ready,
  input  btd_pkg::item_t    item,
  output logic              result_valid,
  input  logic              result_ready,
  output btd_pkg::result_t  result
);

  logic             push_valid;
  logic             push_ready;
  btd_pkg::bundle_t push_bundle;
  logic             pop_valid;
  logic             pop_ready;
  btd_pkg::bundle_t pop_bundle;

  // Front: mark detection and decode
  btd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (item),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_bundle (push_bundle)
  );

  // Bundle queue
  btd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk         (clk),
    .rst         (rst),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_bundle (push_bundle),
    .pop_valid   (pop_valid),
    .pop_ready   (pop_ready),
    .pop_bundle  (pop_bundle)
  );

  // Back: result serializer
  btd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .pop_valid    (pop_valid),
    .pop_ready    (pop_ready),
    .pop_bundle   (pop_bundle),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

/* rtl/btd_checker.sv */
// ----------------------------------------------------------------------------
// btd_checker
// Port-level checks for the text decoder, bound to the top level.
// ----------------------------------------------------------------------------
module btd_checker (
  input logic             clk,
  input logic             rst,
  input logic             item_ready,
  input logic             result_valid,
  input logic             result_ready,
  input btd_pkg::result_t result
);

  // stalled result word holds
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("stalled result word changed");

  // input ready and output empty after reset
  assert property (@(posedge clk) rst |=> item_ready && !result_valid)
    else $error("not empty after reset");

  // end of file closes its word's results
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result.kind == btd_pkg::KIND_EOF |-> result.last)
    else $error("end-of-file result not last");

  // only characters carry a code unit
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result.kind != btd_pkg::KIND_CHAR |-> result.code_unit == 16'd0)
    else $error("code unit on non-character result");

endmodule

bind bom_text_decoder_line_splitter btd_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .item_ready   (item_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);
